// ===== src/sqocc_pkg.sv =====
`default_nettype none

package sqocc_pkg;

  // Geometry of the bitmap
  localparam int unsigned ROW_BITS  = 32;
  localparam int unsigned GRID_ROWS = 32;
  localparam int unsigned IDX_W     = $clog2(GRID_ROWS);
  localparam int unsigned CNT_W     = $clog2(GRID_ROWS + 1);
  localparam int unsigned COL_W     = $clog2(ROW_BITS);
  localparam int unsigned GRID_W    = 6;
  localparam int unsigned SIDE_W    = 6;
  localparam int unsigned SUM_W     = 7;

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(32);
  // Largest usable side: limited by both the row count and the word width
  localparam logic [GRID_W-1:0] GRID_MAX   =
    GRID_W'((GRID_ROWS < ROW_BITS) ? GRID_ROWS : ROW_BITS);

  typedef enum logic [1:0] {
    ACT_TEST   = 2'd0,
    ACT_PLACE  = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_QCOL,
    ST_QCHECK,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;       // latch item, set up first row walk
    logic scan;        // process one row per cycle
    logic check_only;  // row walk only checks the mask against occupied cells
    logic col_find;    // derive column bounds, set up the square check
    logic load_out;    // write the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic is_query;
    logic out_free;
  } sts_t;

  // Mask of columns lo .. hi-1; column j sits at bit ROW_BITS-1-j
  function automatic logic [ROW_BITS-1:0] col_span(input logic [SIDE_W-1:0] lo,
                                                   input logic [SIDE_W-1:0] hi);
    logic [ROW_BITS-1:0] span;
    span = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      span[ROW_BITS-1-j] = (j >= int'(lo)) && (j < int'(hi));
    end
    return span;
  endfunction

endpackage

`default_nettype wire

// ===== src/sqocc_ctrl.sv =====
`default_nettype none

module sqocc_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic               in_stall_o,
  input  sqocc_pkg::sts_t    sts_i,
  output sqocc_pkg::cmd_t    cmd_o
);

  sqocc_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sqocc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sqocc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sqocc_pkg::ST_SCAN;
      end
      sqocc_pkg::ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.is_query ? sqocc_pkg::ST_QCOL : sqocc_pkg::ST_FINISH;
        end
      end
      sqocc_pkg::ST_QCOL: begin
        state_d = sqocc_pkg::ST_QCHECK;
      end
      sqocc_pkg::ST_QCHECK: begin
        if (sts_i.scan_done) state_d = sqocc_pkg::ST_FINISH;
      end
      sqocc_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = sqocc_pkg::ST_IDLE;
      end
      default: begin
        state_d = sqocc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      sqocc_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.start = in_valid_i;
      end
      sqocc_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      sqocc_pkg::ST_QCOL: begin
        cmd_o.col_find = 1'b1;
      end
      sqocc_pkg::ST_QCHECK: begin
        cmd_o.scan       = 1'b1;
        cmd_o.check_only = 1'b1;
      end
      sqocc_pkg::ST_FINISH: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/sqocc_dp.sv =====
`default_nettype none

module sqocc_dp (
  input  wire  logic                            clk_i,
  input  wire  logic                            rst_ni,
  input  wire  logic                            cfg_we_i,
  input  wire  logic [sqocc_pkg::GRID_W-1:0]    cfg_grid_size_i,
  input  wire  logic [1:0]                      action_i,
  input  wire  logic [4:0]                      row_i,
  input  wire  logic [4:0]                      col_i,
  input  wire  logic [sqocc_pkg::SIDE_W-1:0]    side_i,
  input  wire  logic                            out_stall_i,
  output logic                                  out_valid_o,
  output logic                                  fits_o,
  output logic                                  is_square_o,
  output logic [4:0]                            free_row_o,
  output logic [4:0]                            free_col_o,
  output logic [sqocc_pkg::SIDE_W-1:0]          free_side_o,
  input  sqocc_pkg::cmd_t                       cmd_i,
  output sqocc_pkg::sts_t                       sts_o
);

  localparam int unsigned RB = sqocc_pkg::ROW_BITS;
  localparam int unsigned CW = sqocc_pkg::CNT_W;
  localparam int unsigned XW = sqocc_pkg::COL_W;

  // Occupancy bitmap, one word per row
  logic [RB-1:0] occ_q [sqocc_pkg::GRID_ROWS];

  logic [sqocc_pkg::GRID_W-1:0] grid_q;
  sqocc_pkg::action_e           action_q;
  logic [CW-1:0]                cnt_q, end_q;
  logic [RB-1:0]                mask_q, union_q;
  logic                         flag_q, any_q;
  logic [4:0]                   minr_q, maxr_q;
  logic [XW-1:0]                minc_q;
  logic                         out_valid_q;
  logic                         fits_q, is_sq_q;
  logic [4:0]                   fr_q;
  logic [XW-1:0]                fc_q;
  logic [sqocc_pkg::SIDE_W-1:0] fs_q;

  logic [sqocc_pkg::GRID_W-1:0] g;
  logic [sqocc_pkg::SUM_W-1:0]  row_sum, col_sum;
  logic [sqocc_pkg::GRID_W-1:0] rend, cend;
  logic                         in_bounds;
  logic                         row_act;
  logic [sqocc_pkg::IDX_W-1:0]  idx;
  logic [RB-1:0]                cur_row, free_bits;
  logic                         row_we;
  logic [RB-1:0]                row_new;
  logic [XW-1:0]                minc_d, maxc_d;
  logic                         sq_shape;
  logic [CW-1:0]                maxr_next;
  logic [sqocc_pkg::GRID_W-1:0] maxc_next;

  // Active side of the grid
  assign g = (grid_q > sqocc_pkg::GRID_MAX) ? sqocc_pkg::GRID_MAX : grid_q;

  // Request geometry
  assign row_sum   = sqocc_pkg::SUM_W'(row_i) + sqocc_pkg::SUM_W'(side_i);
  assign col_sum   = sqocc_pkg::SUM_W'(col_i) + sqocc_pkg::SUM_W'(side_i);
  assign in_bounds = (row_sum <= sqocc_pkg::SUM_W'(g)) && (col_sum <= sqocc_pkg::SUM_W'(g));
  assign rend      = (row_sum > sqocc_pkg::SUM_W'(g)) ? g : row_sum[sqocc_pkg::GRID_W-1:0];
  assign cend      = (col_sum > sqocc_pkg::SUM_W'(g)) ? g : col_sum[sqocc_pkg::GRID_W-1:0];

  // Current row of the walk
  assign row_act   = cmd_i.scan && (cnt_q < end_q);
  assign idx       = cnt_q[sqocc_pkg::IDX_W-1:0];
  assign cur_row   = occ_q[idx];
  assign free_bits = ~cur_row & mask_q;

  // Row update for place and remove
  always_comb begin
    row_we  = 1'b0;
    row_new = cur_row;
    if (row_act && !cmd_i.check_only) begin
      case (action_q)
        sqocc_pkg::ACT_PLACE: begin
          row_we  = 1'b1;
          row_new = cur_row | mask_q;
        end
        sqocc_pkg::ACT_REMOVE: begin
          row_we  = 1'b1;
          row_new = cur_row & ~mask_q;
        end
        default: begin
          row_we  = 1'b0;
        end
      endcase
    end
  end

  // First and last free column from the union of free rows
  always_comb begin
    minc_d = '0;
    maxc_d = '0;
    for (int j = RB - 1; j >= 0; j--) begin
      if (union_q[RB-1-j]) minc_d = XW'(j);
    end
    for (int j = 0; j < RB; j++) begin
      if (union_q[RB-1-j]) maxc_d = XW'(j);
    end
  end

  assign sq_shape  = any_q && ((maxr_q - minr_q) == 5'(maxc_d - minc_d));
  assign maxr_next = CW'(maxr_q) + CW'(1);
  assign maxc_next = sqocc_pkg::GRID_W'(maxc_d) + sqocc_pkg::GRID_W'(1);

  // Bitmap storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sqocc_pkg::GRID_ROWS; i++) occ_q[i] <= '0;
    end else if (row_we) begin
      occ_q[idx] <= row_new;
    end
  end

  // Grid size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= sqocc_pkg::GRID_RESET;
    end else if (cfg_we_i) begin
      grid_q <= cfg_grid_size_i;
    end
  end

  // Walk control and accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      action_q <= sqocc_pkg::action_e'(action_i);
      any_q    <= 1'b0;
      union_q  <= '0;
      case (sqocc_pkg::action_e'(action_i))
        sqocc_pkg::ACT_TEST: begin
          flag_q <= in_bounds;
          cnt_q  <= CW'(row_i);
          end_q  <= in_bounds ? CW'(row_sum) : CW'(row_i);
          mask_q <= sqocc_pkg::col_span(sqocc_pkg::SIDE_W'(col_i),
                                        col_sum[sqocc_pkg::SIDE_W-1:0]);
        end
        sqocc_pkg::ACT_QUERY: begin
          flag_q <= 1'b0;
          cnt_q  <= '0;
          end_q  <= CW'(g);
          mask_q <= sqocc_pkg::col_span('0, g);
        end
        default: begin
          flag_q <= 1'b0;
          cnt_q  <= CW'(row_i);
          end_q  <= CW'(rend);
          mask_q <= sqocc_pkg::col_span(sqocc_pkg::SIDE_W'(col_i), cend);
        end
      endcase
    end else if (cmd_i.col_find) begin
      minc_q <= minc_d;
      flag_q <= sq_shape;
      cnt_q  <= CW'(minr_q);
      end_q  <= sq_shape ? maxr_next : CW'(minr_q);
      mask_q <= sqocc_pkg::col_span(sqocc_pkg::SIDE_W'(minc_d), maxc_next);
    end else if (row_act) begin
      cnt_q <= cnt_q + CW'(1);
      if (cmd_i.check_only || action_q == sqocc_pkg::ACT_TEST) begin
        if ((cur_row & mask_q) != '0) flag_q <= 1'b0;
      end else if (action_q == sqocc_pkg::ACT_QUERY) begin
        // bounding rows and column union of free cells
        if (free_bits != '0) begin
          if (!any_q) minr_q <= 5'(cnt_q);
          maxr_q  <= 5'(cnt_q);
          any_q   <= 1'b1;
          union_q <= union_q | free_bits;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      fits_q  <= (action_q == sqocc_pkg::ACT_TEST) && flag_q;
      is_sq_q <= (action_q == sqocc_pkg::ACT_QUERY) && flag_q;
      fr_q    <= ((action_q == sqocc_pkg::ACT_QUERY) && any_q) ? minr_q : '0;
      fc_q    <= ((action_q == sqocc_pkg::ACT_QUERY) && any_q) ? minc_q : '0;
      fs_q    <= ((action_q == sqocc_pkg::ACT_QUERY) && flag_q) ?
                 sqocc_pkg::SIDE_W'(maxr_q - minr_q) + sqocc_pkg::SIDE_W'(1) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fits_o      = fits_q;
  assign is_square_o = is_sq_q;
  assign free_row_o  = fr_q;
  assign free_col_o  = 5'(fc_q);
  assign free_side_o = fs_q;

  assign sts_o.scan_done = (cnt_q >= end_q);
  assign sts_o.is_query  = (action_q == sqocc_pkg::ACT_QUERY);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ===== src/square_region_occupancy_map.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Payload
// ------    ---------  ------------------------  -----------------------------------------
// in        input      in_valid_i / in_stall_o   action_i, row_i, col_i, side_i
// out       output     out_valid_o / out_stall_i fits_o, is_square_o, free_row_o,
//                                                free_col_o, free_side_o
// cfg       input      cfg_we_i                  cfg_grid_size_i
//
// One item at a time. Test, place and remove walk the grid rows that the square covers,
// none for a test that lies outside the grid. Query reads the bitmap one row a cycle,
// once over the active side g for the bounds and once over the free square's height h
// to check the square, with no second walk if the bounds are not square.
// Reset clears the whole bitmap at once and sets the grid size to 32.
// A finished item waits in the result register while the next item is accepted; a
// further result waits in the controller until that register is taken.

module square_region_occupancy_map (
  input  wire  logic                          clk_i,
  input  wire  logic                          rst_ni,
  input  wire  logic                          cfg_we_i,
  input  wire  logic [sqocc_pkg::GRID_W-1:0]  cfg_grid_size_i,
  input  wire  logic                          in_valid_i,
  output logic                                in_stall_o,
  input  wire  logic [1:0]                    action_i,
  input  wire  logic [4:0]                    row_i,
  input  wire  logic [4:0]                    col_i,
  input  wire  logic [sqocc_pkg::SIDE_W-1:0]  side_i,
  output logic                                out_valid_o,
  input  wire  logic                          out_stall_i,
  output logic                                fits_o,
  output logic                                is_square_o,
  output logic [4:0]                          free_row_o,
  output logic [4:0]                          free_col_o,
  output logic [sqocc_pkg::SIDE_W-1:0]        free_side_o
);

  sqocc_pkg::cmd_t cmd;
  sqocc_pkg::sts_t sts;

  // Sequencer
  sqocc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Bitmap and row datapath
  sqocc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_grid_size_i (cfg_grid_size_i),
    .action_i        (action_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .side_i          (side_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .fits_o          (fits_o),
    .is_square_o     (is_square_o),
    .free_row_o      (free_row_o),
    .free_col_o      (free_col_o),
    .free_side_o     (free_side_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  // An accepted item keeps the input stalled in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after item accepted");

  // Test and query answers are exclusive
  a_fits_xor_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(fits_o && is_square_o))
    else $error("fits and is_square both set");

  // A square answer carries a nonzero side, and only a square answer does
  a_side_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_square_o) |-> (free_side_o != '0))
    else $error("square reported with zero side");

  a_side_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_square_o) |-> (free_side_o == '0))
    else $error("side reported without a square");

  // Result register is loaded only when free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== tb/tb_square_region_occupancy_map.sv =====
module tb_square_region_occupancy_map;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 133;
  localparam int GRID_PLAN [5] = '{1, 32, 0, 63, 33};

  typedef struct packed {
    sqocc_pkg::action_e action;
    logic [4:0]         row;
    logic [4:0]         col;
    logic [5:0]         side;
  } request_t;

  typedef struct packed {
    logic        fits;
    logic        is_square;
    logic [4:0]  free_row;
    logic [4:0]  free_col;
    logic [5:0]  free_side;
  } answer_t;

  typedef struct packed {
    request_t    rq;
    logic        typed;
    answer_t     ans;
  } directed_row_t;

  // DUT ports
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [5:0]  cfg_grid_size_i = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i        = '0;
  logic [4:0]  row_i           = '0;
  logic [4:0]  col_i           = '0;
  logic [5:0]  side_i          = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic        fits_o;
  logic        is_square_o;
  logic [4:0]  free_row_o;
  logic [4:0]  free_col_o;
  logic [5:0]  free_side_o;

  // Local copy of the bitmap and grid register
  logic [31:0] map_rows [32];
  logic [5:0]  grid_cfg;

  answer_t       expected_answers [$];
  directed_row_t directed_rows [$];
  int            mismatches  = 0;
  int            items_sent  = 0;
  logic          sender_idle = 1'b0;
  logic          stall_idle  = 1'b0;

  square_region_occupancy_map DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_grid_size_i (cfg_grid_size_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .side_i          (side_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .fits_o          (fits_o),
    .is_square_o     (is_square_o),
    .free_row_o      (free_row_o),
    .free_col_o      (free_col_o),
    .free_side_o     (free_side_o)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_square_region_occupancy_map failed");
    $finish;
  end

  // Usable side: register saturated to the bitmap size
  function automatic int active_cells();
    return (grid_cfg > 6'd32) ? 32 : int'(grid_cfg);
  endfunction

  // Columns lo .. hi-1, column 0 at the top bit
  function automatic logic [31:0] col_mask(input int lo, input int hi);
    logic [31:0] m;
    m = '0;
    for (int j = lo; j < hi && j < 32; j++) m[31-j] = 1'b1;
    return m;
  endfunction

  function automatic request_t make_req(input sqocc_pkg::action_e act, input int top,
                                        input int left, input int sd);
    request_t rq;
    rq.action = act;
    rq.row    = 5'(top);
    rq.col    = 5'(left);
    rq.side   = 6'(sd);
    return rq;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Applies one item to the local bitmap and works out its answer
  task automatic predict_occupancy(input request_t rq, output answer_t ans);
    int          g, top, left, sd, rend, cend, minr, maxr, minc, maxc;
    logic        found;
    logic [31:0] m, free_bits;
    ans  = '0;
    g    = active_cells();
    top  = int'(rq.row);
    left = int'(rq.col);
    sd   = int'(rq.side);
    case (rq.action)
      sqocc_pkg::ACT_TEST: begin
        if (top + sd <= g && left + sd <= g) begin
          m = col_mask(left, left + sd);
          ans.fits = 1'b1;
          for (int r = top; r < top + sd; r++) begin
            if ((map_rows[r] & m) != '0) ans.fits = 1'b0;
          end
        end
      end
      sqocc_pkg::ACT_PLACE, sqocc_pkg::ACT_REMOVE: begin
        rend = (top + sd > g) ? g : top + sd;
        cend = (left + sd > g) ? g : left + sd;
        m = col_mask(left, cend);
        for (int r = top; r < rend; r++) begin
          if (rq.action == sqocc_pkg::ACT_PLACE) map_rows[r] = map_rows[r] | m;
          else map_rows[r] = map_rows[r] & ~m;
        end
      end
      default: begin
        // bounding box of the free cells, then check it is a full square
        found = 1'b0;
        minr = 0; maxr = 0; minc = 0; maxc = 0;
        m = col_mask(0, g);
        for (int r = 0; r < g; r++) begin
          free_bits = ~map_rows[r] & m;
          for (int j = 0; j < g; j++) begin
            if (free_bits[31-j]) begin
              if (!found) begin
                minr = r; maxr = r; minc = j; maxc = j;
                found = 1'b1;
              end else begin
                if (r > maxr) maxr = r;
                if (j < minc) minc = j;
                if (j > maxc) maxc = j;
              end
            end
          end
        end
        if (found) begin
          ans.free_row = 5'(minr);
          ans.free_col = 5'(minc);
          if (maxr - minr == maxc - minc) begin
            m = col_mask(minc, maxc + 1);
            ans.is_square = 1'b1;
            for (int r = minr; r <= maxr; r++) begin
              if ((map_rows[r] & m) != '0) ans.is_square = 1'b0;
            end
            if (ans.is_square) ans.free_side = 6'(maxr - minr + 1);
          end
        end
      end
    endcase
  endtask

  // Hands one item over, records its answer, then maybe idles
  task automatic offer(input request_t rq, input logic typed, input answer_t typed_ans);
    answer_t ans;
    int      gap;
    in_valid_i <= 1'b1;
    action_i   <= rq.action;
    row_i      <= rq.row;
    col_i      <= rq.col;
    side_i     <= rq.side;
    do @(posedge clk_i); while (in_stall_o);
    predict_occupancy(rq, ans);
    expected_answers = {expected_answers, (typed ? typed_ans : ans)};
    items_sent++;
    gap = sender_idle ? gap_length() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drow(input sqocc_pkg::action_e act, input int top, input int left,
                      input int sd, input int typed, input int fit, input int sq,
                      input int fr, input int fc, input int fs);
    directed_row_t d;
    d.rq            = make_req(act, top, left, sd);
    d.typed         = (typed != 0);
    d.ans.fits      = (fit != 0);
    d.ans.is_square = (sq != 0);
    d.ans.free_row  = 5'(fr);
    d.ans.free_col  = 5'(fc);
    d.ans.free_side = 6'(fs);
    directed_rows = {directed_rows, d};
  endtask

  // Grid register is only written with nothing in flight
  task automatic set_grid(input int value);
    in_valid_i <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i        <= 1'b1;
    cfg_grid_size_i <= 6'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_cfg = 6'(value);
  endtask

  // Random traffic: fill-and-carve sequences most often, free edits, edge tests, some noise
  task automatic run_phase(input int target);
    int g, pick, top, left, sd, n;
    g = active_cells();
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (g == 0 || pick < 20) begin
        // unconstrained fields
        offer(make_req(sqocc_pkg::action_e'($urandom_range(0, 3)), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom_range(0, 63)), 1'b0, '0);
      end else if (pick < 60) begin
        // fill the grid, carve one hole, maybe spoil it, probe and query
        offer(make_req(sqocc_pkg::ACT_PLACE, 0, 0, g), 1'b0, '0);
        sd   = $urandom_range(1, g);
        top  = $urandom_range(0, g - sd);
        left = $urandom_range(0, g - sd);
        offer(make_req(sqocc_pkg::ACT_REMOVE, top, left, sd), 1'b0, '0);
        if ($urandom_range(0, 9) < 3) begin
          offer(make_req($urandom_range(0, 1) ? sqocc_pkg::ACT_PLACE : sqocc_pkg::ACT_REMOVE,
                         $urandom_range(0, g - 1), $urandom_range(0, g - 1),
                         $urandom_range(1, 2)), 1'b0, '0);
        end
        n = $urandom_range(0, 2);
        repeat (n) begin
          top = $urandom_range(0, g - 1);
          offer(make_req(sqocc_pkg::ACT_TEST, top, $urandom_range(0, g - 1),
                         $urandom_range(0, g - top + 1)), 1'b0, '0);
        end
        offer(make_req(sqocc_pkg::ACT_QUERY, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 63)), 1'b0, '0);
      end else if (pick < 85) begin
        // free edits inside the grid, some clipped at the edge
        if ($urandom_range(0, 9) < 3) begin
          offer(make_req(sqocc_pkg::ACT_REMOVE, 0, 0, g), 1'b0, '0);
        end
        n = $urandom_range(1, 4);
        repeat (n) begin
          top  = $urandom_range(0, g - 1);
          left = $urandom_range(0, g - 1);
          sd   = $urandom_range(1, g - ((top > left) ? top : left)) +
                 (($urandom_range(0, 4) == 0) ? 3 : 0);
          offer(make_req(sqocc_pkg::action_e'($urandom_range(0, 2)), top, left, sd),
                1'b0, '0);
        end
        offer(make_req(sqocc_pkg::ACT_QUERY, 0, 0, 0), 1'b0, '0);
      end else begin
        // test right on the far edge or one past it
        sd   = $urandom_range(0, g);
        top  = g - sd + $urandom_range(0, 1);
        left = $urandom_range(0, g - sd) + $urandom_range(0, 1);
        if (top > 31) top = 31;
        if (left > 31) left = 31;
        if ($urandom_range(0, 1)) offer(make_req(sqocc_pkg::ACT_TEST, top, left, sd), 1'b0, '0);
        else offer(make_req(sqocc_pkg::ACT_TEST, left, top, sd), 1'b0, '0);
      end
    end
  endtask

  // Result side: random stall stretches and the comparison
  initial begin : result_check
    int      hold;
    answer_t want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_answers.size() == 0) begin
          $error("result item with nothing expected");
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          if (fits_o !== want.fits) begin
            $error("fits: expected %0d, got %0d", want.fits, fits_o);
            mismatches++;
          end
          if (is_square_o !== want.is_square) begin
            $error("is_square: expected %0d, got %0d", want.is_square, is_square_o);
            mismatches++;
          end
          if (free_row_o !== want.free_row) begin
            $error("free_row: expected %0d, got %0d", want.free_row, free_row_o);
            mismatches++;
          end
          if (free_col_o !== want.free_col) begin
            $error("free_col: expected %0d, got %0d", want.free_col, free_col_o);
            mismatches++;
          end
          if (free_side_o !== want.free_side) begin
            $error("free_side: expected %0d, got %0d", want.free_side, free_side_o);
            mismatches++;
          end
        end
      end
      if (!stall_idle) begin
        out_stall_i <= 1'b0;
      end else if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 2) == 0) hold = gap_length();
      end
    end
  end

  initial begin : stimulus
    int grid_value;
    for (int r = 0; r < 32; r++) map_rows[r] = '0;
    grid_cfg = 6'd32;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items on the reset grid of 32
    drow(sqocc_pkg::ACT_QUERY,   0,  0,  0, 1, 0, 1,  0,  0, 32);  // empty grid is one square
    drow(sqocc_pkg::ACT_TEST,    0,  0, 32, 1, 1, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_TEST,    0,  0, 33, 1, 0, 0,  0,  0,  0);  // one past the edge
    drow(sqocc_pkg::ACT_TEST,   31, 31,  1, 1, 1, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_TEST,   31, 31,  2, 1, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_TEST,   31,  0, 63, 1, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_TEST,   31, 31,  0, 1, 1, 0,  0,  0,  0);  // zero side
    drow(sqocc_pkg::ACT_PLACE,   0,  0,  0, 1, 0, 0,  0,  0,  0);  // zero side: no change
    drow(sqocc_pkg::ACT_QUERY,   0,  0,  0, 1, 0, 1,  0,  0, 32);
    drow(sqocc_pkg::ACT_PLACE,   0,  0, 32, 1, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_QUERY,  31, 31, 63, 1, 0, 0,  0,  0,  0);  // no free cells
    drow(sqocc_pkg::ACT_TEST,    5,  5,  1, 1, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_TEST,    0,  0,  0, 1, 1, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_REMOVE,  8,  8,  4, 1, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_QUERY,   0,  0,  0, 1, 0, 1,  8,  8,  4);
    drow(sqocc_pkg::ACT_REMOVE,  8, 12,  2, 1, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_QUERY,   0,  0,  0, 0, 0, 0,  0,  0,  0);  // free cells not a square
    drow(sqocc_pkg::ACT_PLACE,   0,  0, 63, 1, 0, 0,  0,  0,  0);  // clipped to the grid
    drow(sqocc_pkg::ACT_REMOVE, 30, 30, 63, 1, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_QUERY,   0,  0,  0, 1, 0, 1, 30, 30,  2);
    drow(sqocc_pkg::ACT_REMOVE, 31,  0,  1, 1, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_QUERY,   0,  0,  0, 0, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_TEST,   30, 30,  2, 0, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_TEST,   30, 29,  2, 0, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_REMOVE,  0,  0, 32, 1, 0, 0,  0,  0,  0);
    drow(sqocc_pkg::ACT_QUERY,   0,  0,  0, 1, 0, 1,  0,  0, 32);
    foreach (directed_rows[k]) begin
      offer(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].ans);
    end

    // Random phases over several grid sizes, out-of-range ones included
    for (int p = 0; p < PHASES; p++) begin
      if (p < 5) grid_value = GRID_PLAN[p];
      else if (p == PHASES - 1) grid_value = 32;
      else grid_value = $urandom_range(2, 31);
      set_grid(grid_value);
      sender_idle = (p % 3 != 1);
      stall_idle  = (p % 3 != 2);
      run_phase(items_sent + PHASE_ITEMS);
    end

    // Drain
    in_valid_i <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_square_region_occupancy_map passed");
    end else begin
      $display("tb_square_region_occupancy_map failed");
    end
    $finish;
  end

endmodule
